>>> rtl/fpce_pkg.sv
package fpce_pkg;

	localparam int PAGE_BYTES_DEF  = 64;
	localparam int FLASH_BYTES_DEF = 32768;
	localparam int BOOT_BYTES_DEF  = 8192;

	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] ERASED   = 8'hFF;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_Q     = 8'h3F;

	localparam logic [7:0] CMD_NONE       = 8'h00;
	localparam logic [7:0] CMD_PROG_MODE  = 8'h50;
	localparam logic [7:0] CMD_LEAVE_PROG = 8'h4C;
	localparam logic [7:0] CMD_AUTO_INC   = 8'h61;
	localparam logic [7:0] CMD_PROG_TYPE  = 8'h70;
	localparam logic [7:0] CMD_VERSION    = 8'h56;
	localparam logic [7:0] CMD_IDENT      = 8'h53;
	localparam logic [7:0] CMD_SIGNATURE  = 8'h73;
	localparam logic [7:0] CMD_DEV_CODE   = 8'h74;
	localparam logic [7:0] CMD_BLOCK_SUP  = 8'h62;
	localparam logic [7:0] CMD_ERASE      = 8'h65;
	localparam logic [7:0] CMD_ADDR       = 8'h41;
	localparam logic [7:0] CMD_SET_DEV    = 8'h54;
	localparam logic [7:0] CMD_BLOCK_LOAD = 8'h42;
	localparam logic [7:0] CMD_BLOCK_READ = 8'h67;

	localparam logic [23:0] SIG_RESET = 24'd2004239;
	localparam logic [7:0]  DEV_RESET = 8'h73;

	localparam logic [0:0] REG_SIGNATURE = 1'b0;
	localparam logic [0:0] REG_DEVICE    = 1'b1;

	typedef enum logic [1:0] {
		MODE_WAIT_ESC,
		MODE_WAIT_S,
		MODE_CMD,
		MODE_DATA
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DECODE,
		ST_REPLY,
		ST_ERASE,
		ST_PROG,
		ST_READ_REQ,
		ST_READ_OUT,
		ST_CR
	} state_t;

	function automatic logic [7:0] ident_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h41;
			3'd1: c = 8'h56;
			3'd2: c = 8'h52;
			3'd3: c = 8'h42;
			3'd4: c = 8'h4F;
			3'd5: c = 8'h4F;
			3'd6: c = 8'h54;
			default: c = 8'h3F;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/flash_programming_command_engine.sv
// Byte-in, byte-out bootloader engine. Each accepted rx_byte yields zero or more
// tx_byte words, the final one flagged by last. Flash sits in a synchronous
// RAM with one read and one write port, so chip erase walks one byte a cycle
// over the application area, page programming writes a whole page before its
// CR, and block read takes each byte through a read state followed by an
// output state. A reply word that is not taken holds the engine. After reset
// the engine clears the whole flash RAM before taking its first byte;
// configuration writes are taken throughout.
module flash_programming_command_engine #(
	parameter int BOOT_BYTES = fpce_pkg::BOOT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import fpce_pkg::*;

	localparam int PAGE_BYTES  = PAGE_BYTES_DEF;
	localparam int FLASH_BYTES = FLASH_BYTES_DEF;
	localparam int FAW = $clog2(FLASH_BYTES);
	localparam int PAW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int LIMIT = FLASH_BYTES - BOOT_BYTES;
	localparam int ERASE_END_R = ((LIMIT + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
	localparam int ERASE_END = (ERASE_END_R > FLASH_BYTES) ? FLASH_BYTES : ERASE_END_R;
	localparam logic [16:0] FLASH_N = 17'(FLASH_BYTES);
	localparam logic [16:0] ERASE_N = 17'(ERASE_END);
	localparam logic [15:0] PAGE_N16 = 16'(PAGE_BYTES);
	localparam logic [PAW:0] PAGE_NP = (PAW+1)'(PAGE_BYTES);

	logic [23:0] signature_q;
	logic [7:0]  device_code_q;
	mode_t       mode_q;
	state_t      state_q, state_d;
	logic [7:0]  pend_q;
	logic [6:0]  argc_q;
	logic [15:0] addr_q;
	logic [15:0] bsize_q;
	logic [7:0]  rx_q;
	logic [16:0] cnt_q;
	logic [7:0]  rbuf_q [7];
	logic [2:0]  rlen_q, ridx_q;

	logic [7:0]  out_byte_q;
	logic        out_last_q, out_valid_q;

	logic            fl_we;
	logic [FAW-1:0]  fl_waddr, fl_raddr;
	logic [7:0]      fl_wdata, fl_rdata;
	logic            pg_we;
	logic [PAW-1:0]  pg_waddr, pg_raddr;
	logic [7:0]      pg_rdata;

	assign cfg_ready = 1'b1;
	assign tx_byte = out_byte_q;
	assign last = out_last_q;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == ST_IDLE);

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	logic out_load;
	assign out_load = out_free && (state_q == ST_REPLY || state_q == ST_READ_OUT
		|| state_q == ST_CR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signature_q <= SIG_RESET;
			device_code_q <= DEV_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SIGNATURE: signature_q <= cfg_data;
				REG_DEVICE:    device_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// page offset and base
	logic [PAW-1:0] off;
	logic [15:0]    base;
	assign off = addr_q[PAW-1:0] & PAW'(PAGE_BYTES - 1);
	assign base = addr_q - 16'(off);

	logic [PAW-1:0] prog_i, pos_s1;
	logic           prog_v_s1, prog_pad_s1;
	assign prog_i = cnt_q[PAW-1:0];

	fpce_flash_mem #(.DEPTH(FLASH_BYTES), .AW(FAW)) u_flash (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rdata));

	fpce_page_mem #(.DEPTH(PAGE_BYTES), .AW(PAW)) u_page (
		.clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(rx_byte),
		.raddr(pg_raddr), .rdata(pg_rdata));

	logic [15:0] fpos16;
	assign fpos16 = base + 16'(pos_s1);

	always_comb begin
		fl_we = 1'b0;
		fl_waddr = cnt_q[FAW-1:0];
		fl_wdata = ERASED;
		fl_raddr = addr_q[FAW-1:0];
		pg_raddr = prog_i;
		if (state_q == ST_CLEAR || state_q == ST_ERASE)
			fl_we = 1'b1;
		if (prog_v_s1) begin
			fl_we = 1'b1;
			fl_waddr = fpos16[FAW-1:0];
			fl_wdata = prog_pad_s1 ? ERASED : pg_rdata;
		end
	end

	assign pg_we = in_valid && in_ready && mode_q == MODE_DATA
		&& (argc_q < 7'(PAGE_BYTES));
	assign pg_waddr = argc_q[PAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_v_s1 <= 1'b0;
		end else begin
			prog_v_s1 <= (state_q == ST_PROG) && (cnt_q < 17'(PAGE_BYTES));
		end
	end

	always_ff @(posedge clk) begin
		logic [PAW:0] p;
		p = (PAW+1)'(off) + (PAW+1)'(prog_i);
		if (p >= PAGE_NP) p = p - PAGE_NP;
		pos_s1 <= p[PAW-1:0];
		prog_pad_s1 <= 16'(prog_i) >= bsize_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DECODE;
			ST_CLEAR:    if (cnt_q == FLASH_N - 17'd1) state_d = ST_IDLE;
			ST_DECODE: begin
				state_d = ST_IDLE;
				unique case (mode_q)
					MODE_WAIT_ESC: if (rx_q != ESC_BYTE) state_d = ST_REPLY;
					MODE_WAIT_S:   if (rx_q == CMD_IDENT) state_d = ST_REPLY;
					MODE_DATA:     if (16'(argc_q + 7'd1) >= bsize_q) state_d = ST_PROG;
					default: begin
						if (pend_q == CMD_NONE) begin
							unique case (rx_q)
								CMD_ERASE: state_d = (ERASE_END > 0) ? ST_ERASE : ST_CR;
								CMD_ADDR, CMD_SET_DEV, CMD_BLOCK_LOAD, CMD_BLOCK_READ,
								ESC_BYTE: state_d = ST_IDLE;
								default: state_d = ST_REPLY;
							endcase
						end else if (pend_q == CMD_SET_DEV) begin
							state_d = ST_CR;
						end else if (pend_q == CMD_ADDR) begin
							if (argc_q != 7'd0) state_d = ST_CR;
						end else if (pend_q == CMD_BLOCK_LOAD || pend_q == CMD_BLOCK_READ) begin
							if (argc_q >= 7'd2) begin
								if (pend_q == CMD_BLOCK_READ) begin
									if (bsize_q != 16'd0) state_d = ST_READ_REQ;
								end else if (bsize_q == 16'd0) begin
									state_d = ST_PROG;
								end
							end
						end
					end
				endcase
			end
			ST_REPLY:    if (out_free && ridx_q == rlen_q - 3'd1) state_d = ST_IDLE;
			ST_ERASE:    if (cnt_q + 17'd1 >= ERASE_N) state_d = ST_CR;
			ST_PROG:     if (cnt_q == 17'(PAGE_BYTES)) state_d = ST_CR;
			ST_READ_REQ: state_d = ST_READ_OUT;
			ST_READ_OUT: if (out_free)
				state_d = (cnt_q == 17'd1) ? ST_IDLE : ST_READ_REQ;
			ST_CR:       if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mode_q <= MODE_WAIT_ESC;
			pend_q <= '0;
			argc_q <= '0;
			addr_q <= '0;
			bsize_q <= '0;
			cnt_q <= '0;
			rlen_q <= '0;
			ridx_q <= '0;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			out_last_q <= 1'b0;
			rx_q <= '0;
			for (int k = 0; k < 7; k++) rbuf_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: cnt_q <= cnt_q + 17'd1;
				ST_IDLE: if (in_valid) rx_q <= rx_byte;
				ST_DECODE: begin
					ridx_q <= '0;
					rlen_q <= '0;
					unique case (mode_q)
						MODE_WAIT_ESC: begin
							if (rx_q == ESC_BYTE) mode_q <= MODE_WAIT_S;
							else begin
								rbuf_q[0] <= CH_Q; rlen_q <= 3'd1;
							end
						end
						MODE_WAIT_S: if (rx_q == CMD_IDENT) begin
							for (int k = 0; k < 7; k++) rbuf_q[k] <= ident_char(3'(k));
							rlen_q <= 3'd7; mode_q <= MODE_CMD;
						end
						MODE_DATA: begin
							logic [6:0] n;
							n = argc_q + 7'd1;
							argc_q <= (16'(n) >= bsize_q) ? 7'd0 : n;
							if (16'(n) >= bsize_q) begin
								mode_q <= MODE_CMD;
								cnt_q <= '0;
							end
						end
						default: begin
							if (pend_q == CMD_NONE) begin
								unique case (rx_q)
									CMD_PROG_MODE, CMD_LEAVE_PROG: begin
										rbuf_q[0] <= CH_CR; rlen_q <= 3'd1;
									end
									CMD_AUTO_INC: begin rbuf_q[0] <= 8'h59; rlen_q <= 3'd1; end
									CMD_PROG_TYPE: begin rbuf_q[0] <= 8'h53; rlen_q <= 3'd1; end
									CMD_VERSION: begin
										rbuf_q[0] <= 8'h31; rbuf_q[1] <= 8'h37; rlen_q <= 3'd2;
									end
									CMD_IDENT: begin
										for (int k = 0; k < 7; k++) rbuf_q[k] <= ident_char(3'(k));
										rlen_q <= 3'd7;
									end
									CMD_SIGNATURE: begin
										rbuf_q[0] <= signature_q[7:0];
										rbuf_q[1] <= signature_q[15:8];
										rbuf_q[2] <= signature_q[23:16];
										rlen_q <= 3'd3;
									end
									CMD_DEV_CODE: begin
										rbuf_q[0] <= device_code_q; rbuf_q[1] <= 8'h00;
										rlen_q <= 3'd2;
									end
									CMD_BLOCK_SUP: begin
										rbuf_q[0] <= 8'h59; rbuf_q[1] <= PAGE_N16[15:8];
										rbuf_q[2] <= PAGE_N16[7:0]; rlen_q <= 3'd3;
									end
									CMD_ERASE: cnt_q <= '0;
									CMD_ADDR, CMD_SET_DEV, CMD_BLOCK_LOAD, CMD_BLOCK_READ: begin
										pend_q <= rx_q; argc_q <= '0;
									end
									ESC_BYTE: ;
									default: begin rbuf_q[0] <= CH_Q; rlen_q <= 3'd1; end
								endcase
							end else if (pend_q == CMD_SET_DEV) begin
								pend_q <= '0;
							end else if (pend_q == CMD_ADDR) begin
								if (argc_q == 7'd0) begin
									addr_q <= {8'h00, rx_q}; argc_q <= 7'd1;
								end else begin
									addr_q <= {addr_q[6:0], rx_q, 1'b0};
									pend_q <= '0; argc_q <= '0;
								end
							end else if (pend_q == CMD_BLOCK_LOAD || pend_q == CMD_BLOCK_READ) begin
								if (argc_q == 7'd0) begin
									bsize_q <= {8'h00, rx_q}; argc_q <= 7'd1;
								end else if (argc_q == 7'd1) begin
									bsize_q <= ({bsize_q[7:0], rx_q} > PAGE_N16) ? PAGE_N16
										: {bsize_q[7:0], rx_q};
									argc_q <= 7'd2;
								end else begin
									pend_q <= '0; argc_q <= '0;
									if (pend_q == CMD_BLOCK_READ) begin
										cnt_q <= 17'(bsize_q);
									end else if (bsize_q == 16'd0) begin
										cnt_q <= '0;
									end else begin
										mode_q <= MODE_DATA;
									end
								end
							end else begin
								pend_q <= '0; argc_q <= '0;
							end
						end
					endcase
				end
				ST_REPLY: if (out_free) begin
					out_valid_q <= 1'b1;
					out_byte_q <= rbuf_q[ridx_q];
					out_last_q <= (ridx_q == rlen_q - 3'd1);
					ridx_q <= ridx_q + 3'd1;
				end
				ST_ERASE: cnt_q <= cnt_q + 17'd1;
				ST_PROG: begin
					cnt_q <= cnt_q + 17'd1;
					if (cnt_q == 17'(PAGE_BYTES))
						addr_q <= addr_q + ((bsize_q + 16'd1) & 16'hFFFE);
				end
				ST_READ_OUT: if (out_free) begin
					out_valid_q <= 1'b1;
					out_byte_q <= fl_rdata;
					out_last_q <= (cnt_q == 17'd1);
					cnt_q <= cnt_q - 17'd1;
					addr_q <= addr_q + 16'd1;
				end
				ST_CR: if (out_free) begin
					out_valid_q <= 1'b1;
					out_byte_q <= CH_CR;
					out_last_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/fpce_flash_mem.sv
module fpce_flash_mem #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/fpce_page_mem.sv
module fpce_page_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
